// ===== rtl/banked_rtc_nibble_registers_defines.svh =====
// Assertion macros shared by the checker.
`ifndef BANKED_RTC_NIBBLE_REGISTERS_DEFINES_SVH
`define BANKED_RTC_NIBBLE_REGISTERS_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BRTC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("brtc assertion failed");

// Next-cycle implication, disabled while in reset.
`define BRTC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("brtc assertion failed");

`endif

// ===== rtl/brtc_pkg.sv =====
`default_nettype none
package brtc_pkg;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam int BANK_DEPTH = 16;
    localparam int FILE_DEPTH = 64;
    localparam int MEM_DEPTH  = FILE_DEPTH - BANK_DEPTH;

    localparam logic [3:0] ADDR_MODE = 4'd13;
    localparam int         MODE_RUN_BIT = 3;

    localparam logic [3:0] POS_SEC  = 4'd0;
    localparam logic [3:0] POS_MIN  = 4'd2;
    localparam logic [3:0] POS_HOUR = 4'd4;
    localparam logic [3:0] POS_DAY  = 4'd7;
    localparam logic [3:0] POS_MON  = 4'd9;
    localparam logic [3:0] POS_YEAR = 4'd11;

    localparam logic [6:0] LIM_SEC  = 7'd60;
    localparam logic [6:0] LIM_MIN  = 7'd60;
    localparam logic [6:0] LIM_HOUR = 7'd24;
    localparam logic [6:0] LIM_MON  = 7'd12;
    localparam logic [6:0] LIM_YEAR = 7'd99;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } dp_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/brtc_ctrl.sv =====
`default_nettype none
module brtc_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output brtc_pkg::dp_cmd_t      dp_cmd
);

    brtc_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= brtc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        dp_cmd.load = 1'b0;
        dp_cmd.exec = 1'b0;
        unique case (state_reg)
            brtc_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                dp_cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = brtc_pkg::ST_EXEC;
                end
            end
            brtc_pkg::ST_EXEC: begin
                // hold until the output slot drains
                dp_cmd.exec = !out_valid_reg || m_tready;
                if (dp_cmd.exec) begin
                    state_next = brtc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = brtc_pkg::ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (dp_cmd.exec) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule
`default_nettype wire

// ===== rtl/brtc_dp.sv =====
`default_nettype none
module brtc_dp (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire brtc_pkg::dp_cmd_t dp_cmd,
    input  wire logic [1:0]        in_command,
    input  wire logic [3:0]        in_address,
    input  wire logic [3:0]        in_write_data,
    output logic [3:0]             read_data
);

    localparam int MemDepth = brtc_pkg::MEM_DEPTH;
    localparam int BankDepth = brtc_pkg::BANK_DEPTH;
    localparam int IdxW = $clog2(MemDepth);

    logic [3:0]      bank0_reg [BankDepth];
    logic [3:0]      bank0_next [BankDepth];
    logic [3:0]      tick_file [BankDepth];
    logic [3:0]      mem [MemDepth];
    logic            valid_reg [MemDepth];

    logic [1:0]      cmd_reg;
    logic [3:0]      addr_reg;
    logic [3:0]      wdata_reg;
    logic [5:0]      tgt_reg, tgt_next;
    logic [3:0]      rdata_reg;
    logic            rvalid_reg;
    logic [3:0]      result_reg, result_next;

    logic [IdxW-1:0] rd_idx, wr_idx;
    logic            rd_in_mem, wr_in_mem, mem_we;

    function automatic logic [7:0] pair_val(input logic [3:0] ones, input logic [3:0] tens);
        return {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {4'b0000, ones};
    endfunction

    // {wrap, tens, ones} after adding one
    function automatic logic [8:0] pair_step(input logic [3:0] ones, input logic [3:0] tens,
                                             input logic [6:0] limit);
        logic [7:0] k;
        logic [4:0] o1;
        logic [3:0] on;
        logic [3:0] tn;
        logic       wrap;
        k    = pair_val(ones, tens) + 8'd1;
        wrap = k >= {1'b0, limit};
        o1   = {1'b0, ones} + 5'd1;
        if (o1 >= 5'd10) begin
            on = 4'(o1 - 5'd10);
            tn = tens + 4'd1;
        end else begin
            on = o1[3:0];
            tn = tens;
        end
        if (wrap) begin
            on = 4'd0;
            tn = 4'd0;
        end
        return {wrap, tn, on};
    endfunction

    function automatic logic [6:0] days_in(input logic [7:0] mon, input logic [7:0] yr);
        logic [6:0] d;
        if (mon == 8'd1) begin
            d = (yr[1:0] == 2'd0) ? 7'd29 : 7'd28;
        end else if (mon == 8'd3 || mon == 8'd5 || mon == 8'd8 || mon == 8'd10) begin
            d = 7'd30;
        end else begin
            d = 7'd31;
        end
        return d;
    endfunction

    // tick cascade over bank 0
    always_comb begin
        logic [8:0] sec_s, min_s, hour_s, day_s, mon_s, year_s;
        logic [6:0] dlim;
        logic       c_sec, c_min, c_hour, c_day, c_mon, c_year;
        for (int i = 0; i < BankDepth; i++) begin
            tick_file[i] = bank0_reg[i];
        end
        dlim   = days_in(pair_val(bank0_reg[brtc_pkg::POS_MON], bank0_reg[brtc_pkg::POS_MON + 4'd1]),
                         pair_val(bank0_reg[brtc_pkg::POS_YEAR],
                                  bank0_reg[brtc_pkg::POS_YEAR + 4'd1]));
        sec_s  = pair_step(bank0_reg[brtc_pkg::POS_SEC], bank0_reg[brtc_pkg::POS_SEC + 4'd1],
                           brtc_pkg::LIM_SEC);
        min_s  = pair_step(bank0_reg[brtc_pkg::POS_MIN], bank0_reg[brtc_pkg::POS_MIN + 4'd1],
                           brtc_pkg::LIM_MIN);
        hour_s = pair_step(bank0_reg[brtc_pkg::POS_HOUR], bank0_reg[brtc_pkg::POS_HOUR + 4'd1],
                           brtc_pkg::LIM_HOUR);
        day_s  = pair_step(bank0_reg[brtc_pkg::POS_DAY], bank0_reg[brtc_pkg::POS_DAY + 4'd1],
                           dlim);
        mon_s  = pair_step(bank0_reg[brtc_pkg::POS_MON], bank0_reg[brtc_pkg::POS_MON + 4'd1],
                           brtc_pkg::LIM_MON);
        year_s = pair_step(bank0_reg[brtc_pkg::POS_YEAR], bank0_reg[brtc_pkg::POS_YEAR + 4'd1],
                           brtc_pkg::LIM_YEAR);
        c_sec  = bank0_reg[brtc_pkg::ADDR_MODE][brtc_pkg::MODE_RUN_BIT];
        c_min  = c_sec & sec_s[8];
        c_hour = c_min & min_s[8];
        c_day  = c_hour & hour_s[8];
        c_mon  = c_day & day_s[8];
        c_year = c_mon & mon_s[8];
        if (c_sec) begin
            tick_file[brtc_pkg::POS_SEC]        = sec_s[3:0];
            tick_file[brtc_pkg::POS_SEC + 4'd1] = sec_s[7:4];
        end
        if (c_min) begin
            tick_file[brtc_pkg::POS_MIN]        = min_s[3:0];
            tick_file[brtc_pkg::POS_MIN + 4'd1] = min_s[7:4];
        end
        if (c_hour) begin
            tick_file[brtc_pkg::POS_HOUR]        = hour_s[3:0];
            tick_file[brtc_pkg::POS_HOUR + 4'd1] = hour_s[7:4];
        end
        if (c_day) begin
            tick_file[brtc_pkg::POS_DAY]        = day_s[3:0];
            tick_file[brtc_pkg::POS_DAY + 4'd1] = day_s[7:4];
        end
        if (c_mon) begin
            tick_file[brtc_pkg::POS_MON]        = mon_s[3:0];
            tick_file[brtc_pkg::POS_MON + 4'd1] = mon_s[7:4];
        end
        if (c_year) begin
            tick_file[brtc_pkg::POS_YEAR]        = year_s[3:0];
            tick_file[brtc_pkg::POS_YEAR + 4'd1] = year_s[7:4];
        end
    end

    always_comb begin
        tgt_next  = (in_address >= brtc_pkg::ADDR_MODE) ? {2'b00, in_address}
                                                        : {bank0_reg[brtc_pkg::ADDR_MODE][1:0],
                                                           in_address};
        rd_in_mem = tgt_next[5:4] != 2'b00;
        rd_idx    = IdxW'(tgt_next - 6'(BankDepth));
        wr_in_mem = tgt_reg[5:4] != 2'b00;
        wr_idx    = IdxW'(tgt_reg - 6'(BankDepth));
        mem_we    = dp_cmd.exec && cmd_reg == brtc_pkg::CMD_WRITE && wr_in_mem;

        result_next = 4'd0;
        if (cmd_reg == brtc_pkg::CMD_READ && addr_reg < brtc_pkg::ADDR_MODE) begin
            if (!wr_in_mem) begin
                result_next = bank0_reg[tgt_reg[3:0]];
            end else if (rvalid_reg) begin
                result_next = rdata_reg;
            end
        end

        for (int i = 0; i < BankDepth; i++) begin
            bank0_next[i] = bank0_reg[i];
        end
        if (dp_cmd.exec) begin
            unique case (cmd_reg)
                brtc_pkg::CMD_WRITE: begin
                    if (!wr_in_mem) begin
                        bank0_next[tgt_reg[3:0]] = wdata_reg;
                    end
                end
                brtc_pkg::CMD_TICK: begin
                    for (int i = 0; i < BankDepth; i++) begin
                        bank0_next[i] = tick_file[i];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < BankDepth; i++) begin
                bank0_reg[i] <= 4'd0;
            end
            for (int i = 0; i < MemDepth; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            for (int i = 0; i < BankDepth; i++) begin
                bank0_reg[i] <= bank0_next[i];
            end
            if (mem_we) begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_idx] <= wdata_reg;
        end
        if (dp_cmd.load && rd_in_mem) begin
            rdata_reg  <= mem[rd_idx];
            rvalid_reg <= valid_reg[rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            cmd_reg   <= in_command;
            addr_reg  <= in_address;
            wdata_reg <= in_write_data;
            tgt_reg   <= tgt_next;
        end
        if (dp_cmd.exec) begin
            result_reg <= result_next;
        end
    end

    assign read_data = result_reg;

endmodule
`default_nettype wire

// ===== rtl/banked_rtc_nibble_registers.sv =====
`default_nettype none
// Banked RTC nibble register file: each accepted beat is a bus read, a bus write, a
// one-second tick or an unused no-op, and returns exactly one result beat (the read
// nibble, or zero). On accept the banked memory (banks 1 to 3) is read into a register;
// the execute step, which waits while the output register is full and not taken, updates
// bank 0 or the memory and loads the output register. The next beat is accepted only
// once execution is done. The output register lets a new beat be accepted while the
// previous result waits. Bank 0 lives in flip-flops, and the 48-entry memory has
// per-entry valid bits cleared at reset, so no clearing pass is needed after reset.
module banked_rtc_nibble_registers (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command[1:0], address[5:2], write_data[9:6]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // read_data[3:0]
);

    brtc_pkg::dp_cmd_t dp_cmd;
    logic [3:0]        read_data;

    brtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .dp_cmd   (dp_cmd)
    );

    brtc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .dp_cmd        (dp_cmd),
        .in_command    (s_tdata[1:0]),
        .in_address    (s_tdata[5:2]),
        .in_write_data (s_tdata[9:6]),
        .read_data     (read_data)
    );

    assign m_tdata = {4'd0, read_data};

endmodule
`default_nettype wire

// ===== rtl/brtc_checker.sv =====
`default_nettype none
`include "banked_rtc_nibble_registers_defines.svh"
module brtc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    logic stall_out;
    logic in_beat;
    logic exec_beat;
    logic blank_beat;

    assign stall_out  = m_tvalid && !m_tready;
    assign in_beat    = s_tvalid && s_tready;
    assign exec_beat  = in_beat && (!m_tvalid || m_tready);
    assign blank_beat = exec_beat && (s_tdata[1:0] != brtc_pkg::CMD_READ);

    `BRTC_ASSERT_NXT(a_out_hold, aclk, aresetn, stall_out, m_tvalid && $stable(m_tdata))
    `BRTC_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, in_beat, !s_tready)
    `BRTC_ASSERT_NXT(a_result_follows, aclk, aresetn, $past(aresetn && exec_beat), m_tvalid)
    `BRTC_ASSERT_NXT(a_nonread_zero, aclk, aresetn, $past(aresetn && blank_beat), m_tdata == 8'd0)

endmodule

bind banked_rtc_nibble_registers brtc_checker u_brtc_checker (.*);
`default_nettype wire

// ===== verif/rtc_nibble_checker.sv =====
module rtc_nibble_checker
    import brtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [15:0] s_tdata,   // command[1:0], address[5:2], write_data[9:6]
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,    // read_data[3:0]
    output int              mismatches,
    output int              outstanding
);

    localparam int YEAR_BASE = 1980;

    logic [3:0] clock_nibbles [FILE_DEPTH];
    logic [3:0] expected_nibbles [$];
    logic [3:0] want;

    function automatic int pair_value(input logic [3:0] pos);
        return int'(clock_nibbles[pos + 4'd1]) * 10 + int'(clock_nibbles[pos]);
    endfunction

    function automatic bit bump_pair(input logic [3:0] pos, input int wrap_at);
        int k;
        k = pair_value(pos) + 1;
        if (k >= wrap_at) begin
            clock_nibbles[pos] = 4'd0;
            clock_nibbles[pos + 4'd1] = 4'd0;
            return 1'b1;
        end
        clock_nibbles[pos] = 4'(k % 10);
        clock_nibbles[pos + 4'd1] = 4'(k / 10);
        return 1'b0;
    endfunction

    function automatic int month_length(input int month, input int year);
        if (month == 2) return (year % 4 == 0) ? 29 : 28;
        if (month == 4 || month == 6 || month == 9 || month == 11) return 30;
        return 31;
    endfunction

    function automatic void advance_second();
        int days;
        if (!clock_nibbles[ADDR_MODE][MODE_RUN_BIT]) return;
        if (!bump_pair(POS_SEC, int'(LIM_SEC))) return;
        if (!bump_pair(POS_MIN, int'(LIM_MIN))) return;
        if (!bump_pair(POS_HOUR, int'(LIM_HOUR))) return;
        days = month_length(pair_value(POS_MON) + 1, YEAR_BASE + pair_value(POS_YEAR));
        if (!bump_pair(POS_DAY, days)) return;
        if (!bump_pair(POS_MON, int'(LIM_MON))) return;
        void'(bump_pair(POS_YEAR, int'(LIM_YEAR)));
    endfunction

    function automatic logic [3:0] predict_nibble(input logic [1:0] cmd,
                                                  input logic [3:0] addr,
                                                  input logic [3:0] data);
        logic [5:0] slot;
        slot = (addr >= ADDR_MODE) ? {2'b00, addr} : {clock_nibbles[ADDR_MODE][1:0], addr};
        case (cmd)
            CMD_READ: begin
                return (addr < ADDR_MODE) ? clock_nibbles[slot] : 4'd0;
            end
            CMD_WRITE: begin
                clock_nibbles[slot] = data;
            end
            CMD_TICK: begin
                advance_second();
            end
            default: begin
            end
        endcase
        return 4'd0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("mismatch: %s got %0d want %0d", what, got, exp_val);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (clock_nibbles[i]) clock_nibbles[i] = 4'd0;
            expected_nibbles.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_nibbles.size() == 0) begin
                    report_mismatch("read_data with no beat pending", int'(m_tdata[3:0]), 0);
                end else begin
                    want = expected_nibbles.pop_front();
                    if (m_tdata[3:0] !== want) begin
                        report_mismatch("read_data", int'(m_tdata[3:0]), int'(want));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_nibbles.push_back(predict_nibble(s_tdata[1:0], s_tdata[5:2],
                                                          s_tdata[9:6]));
            end
        end
        outstanding <= expected_nibbles.size();
    end

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import brtc_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [3:0] ADDR_TEST   = 4'd14;
    localparam logic [3:0] ADDR_RESET  = 4'd15;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         RANDOM_ITEMS = 1200;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [7:0]  m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int sent           = 0;
    int random_start;
    int mismatches;
    int outstanding;

    banked_rtc_nibble_registers uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    rtc_nibble_checker nibble_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [3:0] addr,
                             input logic [3:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, data, addr, cmd};
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic set_clock(input int sec, input int minute, input int hour, input int day,
                             input int month, input int year);
        logic [3:0] pos [6];
        int         val [6];
        pos = '{POS_SEC, POS_MIN, POS_HOUR, POS_DAY, POS_MON, POS_YEAR};
        val = '{sec, minute, hour, day, month, year};
        for (int i = 0; i < 6; i++) begin
            send_beat(CMD_WRITE, pos[i], 4'(val[i] % 10));
            send_beat(CMD_WRITE, pos[i] + 4'd1, 4'(val[i] / 10));
        end
    endtask

    // preset the calendar in the selected bank (mostly bank 0) near a rollover, tick a few times, read that bank back
    task automatic run_scenario();
        logic       running;
        logic [1:0] bank;
        int         reads;
        running = ($urandom_range(9) != 0);
        bank = ($urandom_range(9) == 0) ? 2'($urandom_range(3)) : 2'd0;
        send_beat(CMD_WRITE, ADDR_MODE, {running, 1'($urandom_range(1)), bank});
        set_clock(59 - $urandom_range(2),
                  $urandom_range(1) ? 59 : $urandom_range(59),
                  $urandom_range(1) ? 23 : $urandom_range(23),
                  $urandom_range(30, 25),
                  $urandom_range(13),
                  ($urandom_range(3) == 0) ? 98 : $urandom_range(98));
        repeat ($urandom_range(1, 5)) send_beat(CMD_TICK, 4'($urandom), 4'($urandom));
        reads = ($urandom_range(6) == 0) ? $urandom_range(12) : 13;
        for (int a = 0; a < reads; a++) send_beat(CMD_READ, 4'(a), 4'($urandom));
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(5, 15)) begin
            send_beat(2'($urandom_range(3)), 4'($urandom), 4'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        send_beat(CMD_WRITE, ADDR_MODE, 4'h8);
        send_beat(CMD_READ, ADDR_MODE, 4'hf);
        set_clock(59, 59, 23, 30, 11, 98);
        send_beat(CMD_TICK, 4'd0, 4'd0);
        send_beat(CMD_READ, POS_YEAR + 4'd1, 4'd0);
        send_beat(CMD_READ, ADDR_TEST, 4'd0);
        send_beat(CMD_WRITE, POS_SEC, 4'hf);
        send_beat(CMD_TICK, 4'hf, 4'hf);
        send_beat(CMD_READ, POS_SEC + 4'd1, 4'd0);
        send_beat(CMD_WRITE, ADDR_MODE, 4'ha);
        send_beat(CMD_WRITE, 4'd3, 4'hf);
        send_beat(CMD_READ, 4'd3, 4'd0);
        send_beat(CMD_WRITE, ADDR_MODE, 4'h3);
        send_beat(CMD_TICK, 4'd0, 4'd0);
        send_beat(CMD_READ, 4'd3, 4'd0);
        send_beat(CMD_UNUSED, ADDR_RESET, 4'hf);

        random_start = sent;
        while (sent - random_start < RANDOM_ITEMS) begin
            case ((sent - random_start) * 4 / RANDOM_ITEMS)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_idle_pct = 17;
                    recv_stall_pct = 17;
                end
            endcase
            if ($urandom_range(9) < 7) run_scenario();
            else noise_burst();
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
